>>> design/rqps_pkg.sv
// Shared types, constants and saturating arithmetic for the read quality position statistics unit.
package rqps_pkg;

    localparam int MAX_POSITIONS = 512;
    localparam int NUM_CLASSES   = 8;
    localparam int COUNT_BITS    = 32;
    localparam int SUM_BITS      = 40;
    localparam int POS_BITS      = 16;
    localparam int READS_BITS    = 40;
    localparam int LENGTH_BITS   = 48;
    localparam int CLASS_BITS    = 3;
    localparam int QUAL_BITS     = 7;
    localparam int VALUE_BITS    = 40;

    localparam int POS_IDX_BITS  = $clog2(MAX_POSITIONS);
    localparam int A_DEPTH       = NUM_CLASSES * MAX_POSITIONS;
    localparam int A_ADDR_BITS   = $clog2(A_DEPTH);

    localparam logic [QUAL_BITS-1:0] QUAL_OFFSET  = 7'd33;
    localparam logic [QUAL_BITS-1:0] MIN_RESET    = 7'd127;
    localparam logic [QUAL_BITS-1:0] MAX_RESET    = 7'd33;
    localparam logic [QUAL_BITS-1:0] Q20_RESET    = 7'd53;
    localparam logic [QUAL_BITS-1:0] Q30_RESET    = 7'd63;

    // operation codes
    localparam logic OP_ACCUM = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // table select codes
    localparam logic [2:0] TBL_Q20      = 3'd0;
    localparam logic [2:0] TBL_Q30      = 3'd1;
    localparam logic [2:0] TBL_COUNT    = 3'd2;
    localparam logic [2:0] TBL_QSUM     = 3'd3;
    localparam logic [2:0] TBL_POS_TOT  = 3'd4;
    localparam logic [2:0] TBL_POS_QUAL = 3'd5;

    // register indexes
    localparam logic REG_Q20_THRESH = 1'b0;
    localparam logic REG_Q30_THRESH = 1'b1;

    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [SUM_BITS-1:0]   sum_t;

    // per class and position word
    typedef struct packed {
        count_t q20;
        count_t q30;
        count_t bases;
        sum_t   qsum;
    } class_word_t;

    // per position word
    typedef struct packed {
        count_t bases;
        sum_t   qsum;
    } pos_word_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    function automatic count_t sat_inc(input count_t v);
        count_t r;
        r = (v == '1) ? v : v + count_t'(1);
        return r;
    endfunction

    function automatic sum_t sat_add_q(input sum_t v, input logic [QUAL_BITS-1:0] q);
        logic [SUM_BITS:0] s;
        s = {1'b0, v} + (SUM_BITS + 1)'(q);
        return s[SUM_BITS] ? '1 : s[SUM_BITS-1:0];
    endfunction

    function automatic logic [A_ADDR_BITS-1:0] class_index(
        input logic [CLASS_BITS-1:0]   cls,
        input logic [POS_IDX_BITS-1:0] pos
    );
        logic [A_ADDR_BITS-1:0] r;
        r = A_ADDR_BITS'(cls) * A_ADDR_BITS'(MAX_POSITIONS) + A_ADDR_BITS'(pos);
        return r;
    endfunction

endpackage

>>> design/read_quality_position_stats_unit.sv
// Read quality position statistics unit: per-position Q20/Q30/base/quality tables in two RAMs.
// One beat at a time: accept + RAM read, then modify and write back; a read-out may stall on m_*.
// A read-out result is registered on m_* from ST_EXEC, once the output register is free.
// Reset: aresetn is synchronous, active low; it resets the scalar statistics and the thresholds,
// then a clearing pass zeroes both RAMs, one entry per cycle, over all 8 * MAX_POSITIONS = 4096
// A addresses, during which s_ready stays low. Configuration writes are taken at all times.
module read_quality_position_stats_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input beats
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic [7:0]                         s_base_char,
    input  logic [6:0]                         s_quality_char,
    input  logic                               s_end_of_read,
    input  logic [2:0]                         s_table_select,
    input  logic [2:0]                         s_class_index,
    input  logic [8:0]                         s_read_position,
    // result beats
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [39:0]                        m_counter_value,
    output logic [6:0]                         m_min_quality,
    output logic [6:0]                         m_max_quality,
    output logic [39:0]                        m_read_total,
    output logic [47:0]                        m_length_total,
    output logic                               m_position_overflow
);
    import rqps_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers (thresholds), APB write on access phase
    // ------------------------------------------------------------------
    logic [QUAL_BITS-1:0] q20_thresh_reg;
    logic [QUAL_BITS-1:0] q30_thresh_reg;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q20_thresh_reg <= Q20_RESET;
            q30_thresh_reg <= Q30_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                REG_Q20_THRESH: q20_thresh_reg <= pwdata[QUAL_BITS-1:0];
                REG_Q30_THRESH: q30_thresh_reg <= pwdata[QUAL_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_Q20_THRESH: prdata = 32'(q20_thresh_reg);
            REG_Q30_THRESH: prdata = 32'(q30_thresh_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [A_ADDR_BITS-1:0] clear_addr_reg;
    logic                   clear_last;

    logic [POS_BITS-1:0]    pos_counter_reg;
    logic [QUAL_BITS-1:0]   min_seen_reg;
    logic [QUAL_BITS-1:0]   max_seen_reg;
    logic [READS_BITS-1:0]  reads_done_reg;
    logic [LENGTH_BITS-1:0] length_accum_reg;
    logic                   overflow_reg;

    // beat held across the read-modify-write
    logic                    op_reg;
    logic [QUAL_BITS-1:0]    qch_reg;
    logic                    eor_reg;
    logic [2:0]              sel_reg;
    logic                    rd_pos_ok_reg;
    logic [A_ADDR_BITS-1:0]  a_addr_reg;
    logic [POS_IDX_BITS-1:0] b_addr_reg;

    logic s_accept;
    logic out_free;
    logic exec_accum;
    logic exec_read;

    assign s_accept   = s_valid && s_ready;
    assign out_free   = !m_valid || m_ready;
    assign clear_last = (clear_addr_reg == A_ADDR_BITS'(A_DEPTH - 1));
    assign exec_accum = (state_reg == ST_EXEC) && (op_reg == OP_ACCUM);
    assign exec_read  = (state_reg == ST_EXEC) && (op_reg == OP_READ) && out_free;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clear_last) state_next = ST_IDLE;
            ST_IDLE:  if (s_valid) state_next = ST_EXEC;
            ST_EXEC: begin
                // a read-out waits here while the output register is still full
                if (op_reg == OP_ACCUM || out_free) state_next = ST_IDLE;
            end
            default:  state_next = ST_CLEAR;
        endcase
    end

    // FSM outputs
    always_comb begin
        s_ready = 1'b0;
        unique case (state_reg)
            ST_CLEAR: s_ready = 1'b0;
            ST_IDLE:  s_ready = 1'b1;
            ST_EXEC:  s_ready = 1'b0;
            default:  s_ready = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clear_addr_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) clear_addr_reg <= clear_addr_reg + A_ADDR_BITS'(1);
        end
    end

    // ------------------------------------------------------------------
    // RAM addressing at accept
    // ------------------------------------------------------------------
    logic [POS_IDX_BITS-1:0] rd_pos_sel;
    logic [CLASS_BITS-1:0]   rd_cls_sel;
    logic [A_ADDR_BITS-1:0]  a_rd_addr;

    always_comb begin
        if (s_operation == OP_ACCUM) begin
            rd_pos_sel = POS_IDX_BITS'(pos_counter_reg);
            rd_cls_sel = s_base_char[CLASS_BITS-1:0];
        end else begin
            rd_pos_sel = POS_IDX_BITS'(s_read_position);
            rd_cls_sel = s_class_index;
        end
        a_rd_addr = class_index(rd_cls_sel, rd_pos_sel);
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            op_reg        <= s_operation;
            qch_reg       <= s_quality_char;
            eor_reg       <= s_end_of_read;
            sel_reg       <= s_table_select;
            rd_pos_ok_reg <= (32'(s_read_position) < MAX_POSITIONS);
            a_addr_reg    <= a_rd_addr;
            b_addr_reg    <= rd_pos_sel;
        end
    end

    // ------------------------------------------------------------------
    // RAMs: A per class and position, B per position
    // ------------------------------------------------------------------
    class_word_t mem_a [A_DEPTH];
    pos_word_t   mem_b [MAX_POSITIONS];
    class_word_t a_rd_reg;
    pos_word_t   b_rd_reg;

    logic                    a_we, b_we;
    logic [A_ADDR_BITS-1:0]  a_wr_addr;
    logic [POS_IDX_BITS-1:0] b_wr_addr;
    class_word_t             a_wdata;
    pos_word_t               b_wdata;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            a_rd_reg <= mem_a[a_rd_addr];
            b_rd_reg <= mem_b[rd_pos_sel];
        end
        if (a_we) mem_a[a_wr_addr] <= a_wdata;
        if (b_we) mem_b[b_wr_addr] <= b_wdata;
    end

    // ------------------------------------------------------------------
    // Accumulate datapath
    // ------------------------------------------------------------------
    logic [QUAL_BITS-1:0] q_val;
    logic                 pos_ok;
    logic                 is_q30, is_q20;

    assign q_val  = (qch_reg >= QUAL_OFFSET) ? (qch_reg - QUAL_OFFSET) : '0;
    assign pos_ok = (32'(pos_counter_reg) < MAX_POSITIONS);
    assign is_q30 = (qch_reg > q30_thresh_reg);
    assign is_q20 = is_q30 || (qch_reg > q20_thresh_reg);

    always_comb begin
        if (state_reg == ST_CLEAR) begin
            // clearing pass: zero A every cycle, B while the sweep is inside its range
            a_we      = 1'b1;
            a_wr_addr = clear_addr_reg;
            a_wdata   = '0;
            b_we      = (32'(clear_addr_reg) < MAX_POSITIONS);
            b_wr_addr = POS_IDX_BITS'(clear_addr_reg);
            b_wdata   = '0;
        end else begin
            a_we            = exec_accum && pos_ok;
            a_wr_addr       = a_addr_reg;
            a_wdata.q20     = is_q20 ? sat_inc(a_rd_reg.q20) : a_rd_reg.q20;
            a_wdata.q30     = is_q30 ? sat_inc(a_rd_reg.q30) : a_rd_reg.q30;
            a_wdata.bases   = sat_inc(a_rd_reg.bases);
            a_wdata.qsum    = sat_add_q(a_rd_reg.qsum, q_val);
            b_we            = exec_accum && pos_ok;
            b_wr_addr       = b_addr_reg;
            b_wdata.bases   = sat_inc(b_rd_reg.bases);
            b_wdata.qsum    = sat_add_q(b_rd_reg.qsum, q_val);
        end
    end

    // scalar totals
    logic [POS_BITS:0]      read_len;
    logic [LENGTH_BITS:0]   length_sum;

    assign read_len   = {1'b0, pos_counter_reg} + (POS_BITS + 1)'(1);
    assign length_sum = {1'b0, length_accum_reg} + (LENGTH_BITS + 1)'(read_len);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_counter_reg  <= '0;
            min_seen_reg     <= MIN_RESET;
            max_seen_reg     <= MAX_RESET;
            reads_done_reg   <= '0;
            length_accum_reg <= '0;
            overflow_reg     <= 1'b0;
        end else if (exec_accum) begin
            if (q_val < min_seen_reg) min_seen_reg <= q_val;
            if (q_val > max_seen_reg) max_seen_reg <= q_val;
            if (!pos_ok) overflow_reg <= 1'b1;
            if (eor_reg) begin
                if (reads_done_reg != '1) reads_done_reg <= reads_done_reg + READS_BITS'(1);
                length_accum_reg <= length_sum[LENGTH_BITS] ? '1 : length_sum[LENGTH_BITS-1:0];
                pos_counter_reg  <= '0;
            end else if (pos_counter_reg != '1) begin
                // position saturates on very long reads
                pos_counter_reg <= pos_counter_reg + POS_BITS'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // Read-out and output register
    // ------------------------------------------------------------------
    logic [63:0] sel_value;

    always_comb begin
        sel_value = '0;
        case (sel_reg)
            TBL_Q20:      sel_value = 64'(a_rd_reg.q20);
            TBL_Q30:      sel_value = 64'(a_rd_reg.q30);
            TBL_COUNT:    sel_value = 64'(a_rd_reg.bases);
            TBL_QSUM:     sel_value = 64'(a_rd_reg.qsum);
            TBL_POS_TOT:  sel_value = 64'(b_rd_reg.bases);
            TBL_POS_QUAL: sel_value = 64'(b_rd_reg.qsum);
            default:      sel_value = '0;
        endcase
        if (!rd_pos_ok_reg) sel_value = '0;
    end

    logic                    m_valid_reg;
    logic [VALUE_BITS-1:0]   m_value_reg;
    logic [QUAL_BITS-1:0]    m_min_reg, m_max_reg;
    logic [READS_BITS-1:0]   m_reads_reg;
    logic [LENGTH_BITS-1:0]  m_length_reg;
    logic                    m_overflow_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (exec_read) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_read) begin
            m_value_reg    <= sel_value[VALUE_BITS-1:0];
            m_min_reg      <= min_seen_reg;
            m_max_reg      <= max_seen_reg;
            m_reads_reg    <= reads_done_reg;
            m_length_reg   <= length_accum_reg;
            m_overflow_reg <= overflow_reg;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_counter_value     = m_value_reg;
    assign m_min_quality       = m_min_reg;
    assign m_max_quality       = m_max_reg;
    assign m_read_total        = m_reads_reg;
    assign m_length_total      = m_length_reg;
    assign m_position_overflow = m_overflow_reg;

endmodule
